FILE: rtl/gaussian_kernel_type_vote_assert.svh
// Assertion macros shared by the gaussian kernel type vote RTL.
// Depends on nothing; included by modules that check their own logic.
`ifndef GAUSSIAN_KERNEL_TYPE_VOTE_ASSERT_SVH
`define GAUSSIAN_KERNEL_TYPE_VOTE_ASSERT_SVH
`ifndef SYNTHESIS
`define GKV_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GKV_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define GKV_ASSERT(label, clk, rst_n, prop, msg)
`define GKV_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

FILE: rtl/gkv_pkg.sv
// Package for the gaussian kernel type vote block: constants, types, kernel table.
// Depends on nothing.
package gkv_pkg;
    localparam int STORE_DEPTH_DEF = 64;
    localparam int NUM_TYPES_DEF = 4;
    localparam int KERNEL_TABLE_DEPTH_DEF = 256;
    localparam int FRAME_W = 32;
    localparam int POS_W = 16;
    localparam int TYPE_W = 2;
    localparam int KERN_W = 17;
    localparam int TOTAL_W = 40;
    localparam logic [63:0] DECAY_Q32 = 64'd4062864982;

    localparam logic [1:0] REG_KEEP = 2'd0;
    localparam logic [1:0] REG_BTYPE = 2'd1;
    localparam logic [1:0] REG_GAIN = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PURGE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // Data handed from one cell to the next on a shift.
    typedef struct packed {
        logic              valid;
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [POS_W-1:0]  z;
        logic [TYPE_W-1:0] ptype;
        logic [FRAME_W-1:0] frame;
    } cell_data_t;

    // Kernel table entry i: round(65536 * e^(-i/18)), built as the model does.
    function automatic logic [KERN_W-1:0] kernel_entry(input int idx);
        logic [63:0]  acc;
        logic [127:0] prod;
        acc = 64'd1 << 32;
        for (int i = 0; i < idx; i++) begin
            prod = acc * DECAY_Q32;
            acc = prod[95:32];
        end
        return KERN_W'((acc + 64'd32768) >> 16);
    endfunction
endpackage

FILE: rtl/gkv_cell.sv
// One storage cell of the point chain: holds a point and shifts it on.
// Depends on gkv_pkg.
module gkv_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               shift,
    input  logic               drop,
    input  gkv_pkg::cell_data_t din,
    output gkv_pkg::cell_data_t dout
);
    import gkv_pkg::*;

    cell_data_t data_reg;
    logic       valid_reg;
    logic       valid_next;

    // Valid bit: follows the neighbor on a shift, cleared on a drop during a shift.
    always_comb
    begin
        valid_next = valid_reg;
        if (shift)
        begin
            valid_next = din.valid && !drop;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            data_reg <= din;
        end
    end

    always_comb
    begin
        dout = data_reg;
        dout.valid = valid_reg;
    end
endmodule

FILE: rtl/gkv_eval.sv
// Scoring pipeline: kernel of squared distance times age weight per point.
// Depends on gkv_pkg.
module gkv_eval #(
    parameter int KERNEL_TABLE_DEPTH = gkv_pkg::KERNEL_TABLE_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  gkv_pkg::cell_data_t         pt,
    input  logic [gkv_pkg::POS_W-1:0]   qx,
    input  logic [gkv_pkg::POS_W-1:0]   qy,
    input  logic [gkv_pkg::POS_W-1:0]   qz,
    input  logic [gkv_pkg::FRAME_W-1:0] qf,
    output logic                        out_valid,
    output logic [gkv_pkg::TYPE_W-1:0]  out_type,
    output logic [gkv_pkg::KERN_W-1:0]  out_weight
);
    import gkv_pkg::*;
    localparam int IW = $clog2(KERNEL_TABLE_DEPTH);

    logic [KERN_W-1:0] ktab [KERNEL_TABLE_DEPTH];
    for (genvar g = 0; g < KERNEL_TABLE_DEPTH; g++)
    begin : g_tab
        assign ktab[g] = kernel_entry(g);
    end

    logic signed [POS_W:0] dx, dy, dz;
    logic signed [33:0] sqx, sqy, sqz;
    logic [33:0] sx_reg, sy_reg, sz_reg;
    logic [31:0] age_reg, age_next;
    logic [TYPE_W-1:0] t1_reg, t2_reg;
    logic v1_reg, v2_reg;
    logic [35:0] d2;
    logic [KERN_W-1:0] w_next;

    assign dx = $signed({pt.x[POS_W-1], pt.x}) - $signed({qx[POS_W-1], qx});
    assign dy = $signed({pt.y[POS_W-1], pt.y}) - $signed({qy[POS_W-1], qy});
    assign dz = $signed({pt.z[POS_W-1], pt.z}) - $signed({qz[POS_W-1], qz});
    assign sqx = dx * dx;
    assign sqy = dy * dy;
    assign sqz = dz * dz;
    assign age_next = qf - pt.frame;

    // Stage one: squares and age.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= en && pt.valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sx_reg  <= unsigned'(sqx);
        sy_reg  <= unsigned'(sqy);
        sz_reg  <= unsigned'(sqz);
        age_reg <= age_next;
        t1_reg  <= pt.ptype;
        t2_reg  <= t1_reg;
        out_weight <= w_next;
    end

    // Stage two: sum, table lookup and age shift.
    always_comb
    begin
        d2 = 36'(sx_reg) + 36'(sy_reg) + 36'(sz_reg);
        w_next = '0;
        if ((d2 >> 8) < 36'(KERNEL_TABLE_DEPTH) && age_reg < 32'd32)
        begin
            w_next = ktab[d2[IW+7:8]] >> age_reg[4:0];
        end
    end

    assign out_valid = v2_reg;
    assign out_type  = t2_reg;
endmodule

FILE: rtl/gaussian_kernel_type_vote.sv
// Gaussian kernel type vote top level; depends on gkv_pkg, gkv_cell, gkv_eval and the
// assertion header. A query item rotates the point chain once, one cell reaching the
// scoring pipeline per cycle.
// The input takes no new item until an insert has finished its purge or a query has
// put its result into the output register, where the result waits.
// Reset clears the chain valid bits and counters and presets the configuration registers at once.
`include "gaussian_kernel_type_vote_assert.svh"
module gaussian_kernel_type_vote #(
    parameter int STORE_DEPTH = gkv_pkg::STORE_DEPTH_DEF,
    parameter int NUM_TYPES = gkv_pkg::NUM_TYPES_DEF,
    parameter int KERNEL_TABLE_DEPTH = gkv_pkg::KERNEL_TABLE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic signed [15:0] pos_x,
    input  logic signed [15:0] pos_y,
    input  logic signed [15:0] pos_z,
    input  logic [1:0]  point_type,
    input  logic [31:0] frame_number,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  result_type
);
    import gkv_pkg::*;
    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam int AW = $clog2(STORE_DEPTH);

    // Configuration registers.
    logic [7:0] keep_reg;
    logic [1:0] btype_reg;
    logic [9:0] gain_reg;
    logic       wr_en;
    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_reg  <= 8'd3;
            btype_reg <= 2'd1;
            gain_reg  <= 10'd307;
        end
        else if (wr_en && paddr[1:0] == 2'b00)
        begin
            unique case (paddr[3:2])
                REG_KEEP:  keep_reg  <= pwdata[7:0];
                REG_BTYPE: btype_reg <= pwdata[1:0];
                REG_GAIN:  gain_reg  <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_KEEP:  prdata = {24'd0, keep_reg};
            REG_BTYPE: prdata = {30'd0, btype_reg};
            REG_GAIN:  prdata = {22'd0, gain_reg};
            default:   prdata = '0;
        endcase
    end

    // Chain of cells: index 0 is the newest, the oldest sits at count-1.
    // Rotation feeds the head cell back to cell 0 for a query sweep.
    cell_data_t chain [STORE_DEPTH];
    cell_data_t chain_in [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] shift_en, drop_en;

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] step_reg, step_next;
    logic [POS_W-1:0] qx_reg, qy_reg, qz_reg;
    logic [FRAME_W-1:0] qf_reg, limit_reg;
    logic [FRAME_W-1:0] old_frame_reg;
    logic [AW-1:0] old_idx;
    logic purge_ok_reg;
    logic purge_ph_reg, purge_ph_next;
    logic purge_hit;
    logic [2:0] drain_reg, drain_next;
    logic in_acc, ins_acc, qry_acc;
    logic done;
    cell_data_t new_pt;

    assign in_acc  = in_valid && in_ready;
    assign ins_acc = in_acc && !action;
    assign qry_acc = in_acc && action;
    assign in_ready = (state_reg == ST_IDLE);
    assign old_idx = AW'(count_reg - 1'b1);

    always_comb
    begin
        new_pt.valid = 1'b1;
        new_pt.x = pos_x;
        new_pt.y = pos_y;
        new_pt.z = pos_z;
        new_pt.ptype = point_type;
        new_pt.frame = frame_number;
    end

    // Insert shifts every cell; a query rotates so the last cell wraps round to cell 0.
    logic rotate;
    assign rotate = (state_reg == ST_SCAN) && (step_reg != '0);
    always_comb
    begin
        chain_in[0] = rotate ? chain[STORE_DEPTH-1] : new_pt;
        shift_en = {STORE_DEPTH{ins_acc || rotate}};
        drop_en = '0;
        for (int i = 1; i < STORE_DEPTH; i++)
        begin
            chain_in[i] = chain[i-1];
        end
    end

    for (genvar g = 0; g < STORE_DEPTH; g++)
    begin : g_cell
        gkv_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (shift_en[g]),
            .drop  (drop_en[g]),
            .din   (chain_in[g]),
            .dout  (chain[g])
        );
    end

    // Purge works in two phases: the oldest frame is read into a register,
    // then compared; each expired point takes both phases.
    assign purge_hit = (state_reg == ST_PURGE) && purge_ph_reg && purge_ok_reg
                       && (count_reg != '0) && (old_frame_reg < limit_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (ins_acc) state_next = ST_PURGE;
                else if (qry_acc) state_next = ST_SCAN;
            end
            ST_PURGE:
            begin
                if (purge_ph_reg && !purge_hit)
                    state_next = ST_IDLE;
            end
            ST_SCAN:  if (step_reg == '0) state_next = ST_FINISH;
            ST_FINISH: if (done) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Counters.
    always_comb
    begin
        count_next = count_reg;
        step_next = step_reg;
        drain_next = drain_reg;
        purge_ph_next = (state_reg == ST_PURGE) && !purge_ph_reg;
        if (ins_acc && count_reg != CW'(STORE_DEPTH)) count_next = count_reg + 1'b1;
        if (purge_hit) count_next = count_reg - 1'b1;
        if (qry_acc) step_next = CW'(STORE_DEPTH);
        else if (rotate) step_next = step_reg - 1'b1;
        if (state_reg == ST_SCAN) drain_next = 3'd4;
        else if (state_reg == ST_FINISH && drain_reg != '0) drain_next = drain_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            step_reg  <= '0;
            drain_reg <= '0;
            purge_ok_reg <= 1'b0;
            purge_ph_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            step_reg  <= step_next;
            drain_reg <= drain_next;
            purge_ph_reg <= purge_ph_next;
            if (ins_acc) purge_ok_reg <= frame_number >= {24'd0, keep_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        old_frame_reg <= chain[old_idx].frame;
        if (in_acc)
        begin
            qx_reg <= pos_x;
            qy_reg <= pos_y;
            qz_reg <= pos_z;
            qf_reg <= frame_number;
            limit_reg <= frame_number - {24'd0, keep_reg};
        end
    end

    // Scoring: the head cell is the one that just rotated; only counted cells score.
    // Rotated cells beyond count hold invalid or stale purged data.
    cell_data_t score_pt;
    logic [CW-1:0] pos_reg;
    always_comb
    begin
        score_pt = chain[STORE_DEPTH-1];
        score_pt.valid = chain[STORE_DEPTH-1].valid && (pos_reg < count_reg);
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) pos_reg <= '0;
        else if (qry_acc) pos_reg <= CW'(STORE_DEPTH - 1);
        else if (rotate) pos_reg <= pos_reg - 1'b1;
    end

    logic              ev_valid;
    logic [TYPE_W-1:0] ev_type;
    logic [KERN_W-1:0] ev_w;
    gkv_eval #(.KERNEL_TABLE_DEPTH(KERNEL_TABLE_DEPTH)) u_eval (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (rotate),
        .pt         (score_pt),
        .qx         (qx_reg),
        .qy         (qy_reg),
        .qz         (qz_reg),
        .qf         (qf_reg),
        .out_valid  (ev_valid),
        .out_type   (ev_type),
        .out_weight (ev_w)
    );

    // Per-type totals and final vote.
    logic [TOTAL_W-1:0] tot_reg [NUM_TYPES];
    logic [TOTAL_W-1:0] fin [NUM_TYPES];
    logic [TOTAL_W+9:0] boosted;
    logic [TOTAL_W-1:0] best;
    logic [1:0] win;
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_TYPES; i++)
        begin
            if (qry_acc) tot_reg[i] <= '0;
            else if (ev_valid && int'(ev_type) == i) tot_reg[i] <= tot_reg[i] + TOTAL_W'(ev_w);
        end
    end
    always_comb
    begin
        boosted = '0;
        for (int i = 0; i < NUM_TYPES; i++)
        begin
            fin[i] = tot_reg[i];
            if (int'(btype_reg) == i)
            begin
                boosted = (TOTAL_W+10)'(tot_reg[i]) * (TOTAL_W+10)'(gain_reg);
                fin[i] = TOTAL_W'(boosted >> 8);
            end
        end
        best = '0;
        win = '0;
        for (int i = 0; i < NUM_TYPES; i++)
        begin
            if (fin[i] > best)
            begin
                best = fin[i];
                win = 2'(i);
            end
        end
    end

    // Output register: a finished query waits until the slot is free.
    assign done = (state_reg == ST_FINISH) && (drain_reg == '0) && (!out_valid || out_ready);
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) out_valid <= 1'b0;
        else if (done) out_valid <= 1'b1;
        else if (out_ready) out_valid <= 1'b0;
    end
    always_ff @(posedge clk)
    begin
        if (done) result_type <= win;
    end

    `GKV_ASSERT(a_cnt_max, clk, rst_n, (count_reg <= CW'(STORE_DEPTH)), "count overflow")
    `GKV_ASSERT_NEXT(a_no_acc_busy, clk, rst_n, (state_reg != ST_IDLE), (!ins_acc || state_reg == ST_IDLE || $past(state_reg) == ST_FINISH), "accept while busy")
    `GKV_ASSERT_NEXT(a_done_out, clk, rst_n, done, out_valid, "result lost")
endmodule
